// ----- src/sse_pkg.sv -----
`default_nettype none
package sse_pkg;
  localparam logic [1:0] GAP_HALVING = 2'd0;
  localparam logic [1:0] GAP_POW2M1  = 2'd1;
  localparam logic [1:0] GAP_FIB     = 2'd2;
  localparam logic [1:0] REG_GAP_MODE = 2'd0;
endpackage
`default_nettype wire

// ----- src/sse_if.sv -----
`default_nettype none
interface sse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        last;
  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface sse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_value;
  logic        final_res;
  logic        overflow;
  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input final_res, input overflow,
                output ready);
endinterface
`default_nettype wire

// ----- src/sse_gap_gen.sv -----
`default_nettype none
// Produces the gap sequence in descending order, one step per request.
module sse_gap_gen
  import sse_pkg::*;
#(
  parameter int CW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          step,
  input  wire logic [1:0]    mode,
  input  wire logic [CW-1:0] n,
  output logic      [CW-1:0] gap,
  output logic               busy
);
  logic [CW:0] a, b;      // fib pair: a = current gap, b = next larger
  logic [CW:0] up_a, up_b;
  logic        climbing;
  logic [CW:0] cur;

  // Climb to the largest term below n (halving mode starts at n/2), then walk down.
  always_ff @(posedge clk) begin
    if (rst) begin
      climbing <= 1'b0;
      busy     <= 1'b0;
    end else if (start) begin
      unique case (mode)
        GAP_POW2M1, GAP_FIB: begin
          cur      <= {{CW{1'b0}}, 1'b1};
          a        <= {{CW{1'b0}}, 1'b1};
          b        <= (CW+1)'(2);
          climbing <= (n > 1);
          busy     <= 1'b0;
        end
        default: begin
          cur      <= {1'b0, n} >> 1;
          climbing <= 1'b0;
          busy     <= (n > 1);
        end
      endcase
    end else if (climbing) begin
      if (mode == GAP_POW2M1) begin
        if (((cur << 1) | 1'b1) < {1'b0, n}) cur <= (cur << 1) | 1'b1;
        else begin
          climbing <= 1'b0;
          busy     <= 1'b1;
        end
      end else begin
        if (b < {1'b0, n}) begin
          a   <= b;
          b   <= up_b;
          cur <= b;
        end else begin
          climbing <= 1'b0;
          busy     <= 1'b1;
        end
      end
    end else if (busy && step) begin
      if (cur == 1) busy <= 1'b0;
      else if (mode == GAP_POW2M1) cur <= cur >> 1;
      else if (mode == GAP_FIB) begin
        cur <= up_a;
        a   <= up_a;
        b   <= a;
      end else cur <= cur >> 1;
    end
  end

  always_comb begin
    up_b = a + b;
    // previous fib: b - a gives the term before a (sequence 1,2,3,5,...)
    up_a = (a == 2) ? (CW+1)'(1) : (b - a);
  end

  assign gap = cur[CW-1:0];
endmodule
`default_nettype wire

// ----- src/shell_sort_engine.sv -----
// Channel | dir | fields
// in_ch   | in  | value[31:0] signed, last
// out_ch  | out | sorted_value[31:0] signed, final_res, overflow
// apb     | in  | gap_mode at 0x0
// Loading takes one transaction per cycle. Emitting each result takes an address state, then
// a registered read-data state, and waits while the receiver holds off.
// Sorting uses one shared compare unit: per gap, each element passes S_IOUT, S_RDTMP, S_TMP,
// S_RDJ, S_CMP, S_PUT; each shift repeats S_RDJ, S_CMP; a gap change adds S_IOUT, S_GWAIT.
// rst is synchronous; store contents are undefined after reset.
// Input is not ready from the last transaction of a set until its final result is registered.
`default_nettype none
module shell_sort_engine
  import sse_pkg::*;
#(
  parameter int MAX_ELEMS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  sse_in_if.sink       in_ch,
  sse_out_if.source    out_ch,
  input  wire logic    psel,
  input  wire logic    penable,
  input  wire logic    pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int AW = $clog2(MAX_ELEMS);
  localparam int CW = $clog2(MAX_ELEMS + 1);

  localparam logic [3:0] S_LOAD = 4'd0, S_GSTART = 4'd1, S_GWAIT = 4'd2,
                         S_IOUT = 4'd3, S_RDTMP = 4'd4, S_TMP = 4'd5,
                         S_RDJ = 4'd6, S_CMP = 4'd7, S_PUT = 4'd8,
                         S_EMRD = 4'd9, S_EMIT = 4'd10;

  logic [3:0]    state;
  logic [1:0]    gap_mode;
  logic [31:0]   mem [MAX_ELEMS];
  logic [31:0]   rdata;
  logic [CW-1:0] count, i, j;
  logic          dropped;
  logic [31:0]   tmp;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;
  logic          g_start, g_step, g_busy;
  logic [CW-1:0] gap;
  logic          in_acc, out_acc;

  assign pready = 1'b1;
  assign prdata = {30'd0, gap_mode};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) gap_mode <= GAP_HALVING;
    else if (psel && penable && pwrite && paddr == REG_GAP_MODE) gap_mode <= pwdata[1:0];
  end

  sse_gap_gen #(.CW(CW)) u_gap (
    .clk, .rst, .start(g_start), .step(g_step), .mode(gap_mode), .n(count),
    .gap, .busy(g_busy)
  );

  // Element store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign in_ch.ready = (state == S_LOAD);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign g_start = (state == S_GSTART);
  assign g_step = (state == S_IOUT) && (i >= count);

  // Memory port muxing
  always_comb begin
    we = 1'b0;
    waddr = count[AW-1:0];
    wdata = in_ch.value;
    raddr = i[AW-1:0];
    unique case (state)
      S_LOAD: we = in_acc && (count < CW'(MAX_ELEMS));
      S_RDJ: raddr = AW'(j - gap);
      S_CMP: begin
        waddr = j[AW-1:0];
        wdata = rdata;
        we = (j >= gap) && ($signed(rdata) > $signed(tmp));
      end
      S_PUT: begin
        waddr = j[AW-1:0];
        wdata = tmp;
        we = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      dropped <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (in_acc) begin
          if (count < CW'(MAX_ELEMS)) count <= count + 1'b1;
          else dropped <= 1'b1;
          if (in_ch.last) state <= S_GSTART;
        end
        S_GSTART: state <= S_GWAIT;
        // A set of one element has no gaps; otherwise wait for the generator to settle
        S_GWAIT: if (g_busy || count <= CW'(1)) begin
          i <= g_busy ? gap : '0;
          state <= g_busy ? S_IOUT : S_EMRD;
        end
        S_IOUT: begin
          if (i < count) state <= S_RDTMP;
          else if (g_busy && gap != 1) begin
            state <= S_GWAIT;
          end else begin
            i <= '0;
            state <= S_EMRD;
          end
        end
        S_RDTMP: state <= S_TMP;
        S_TMP: begin
          tmp <= rdata;
          j <= i;
          state <= S_RDJ;
        end
        S_RDJ: state <= (j >= gap) ? S_CMP : S_PUT;
        S_CMP: begin
          if (we) begin
            j <= j - gap;
            state <= S_RDJ;
          end else state <= S_PUT;
        end
        S_PUT: begin
          i <= i + 1'b1;
          state <= S_IOUT;
        end
        S_EMRD: begin
          if (!out_ch.valid || out_acc) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_ch.valid <= 1'b1;
          out_ch.sorted_value <= rdata;
          out_ch.final_res <= (i + 1'b1 == count);
          out_ch.overflow <= dropped;
          if (i + 1'b1 == count) begin
            count <= '0;
            dropped <= 1'b0;
            state <= S_LOAD;
          end else begin
            i <= i + 1'b1;
            state <= S_EMRD;
          end
        end
        default: state <= S_LOAD;
      endcase
      if (out_acc && state != S_EMIT) out_ch.valid <= 1'b0;
    end
  end

  // Checks
  a_no_in_when_sorting: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_ch.ready) else $error("input ready outside load");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMS)) else $error("count beyond capacity");
  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && i + 1'b1 == count) |=> (count == 0 && !dropped))
    else $error("set not cleared");
endmodule
`default_nettype wire

// ----- test/shell_sort_engine_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module shell_sort_engine_test
  import sse_pkg::*;
();

  localparam int CAP = 64;

  // One expected sorted element
  typedef struct packed {
    logic [31:0] sorted_value;
    logic        final_res;
    logic        overflow;
  } sorted_elem_t;

  // Golden sorter: collects the loaded set, sorts it, queues expected elements
  class sort_scoreboard;
    logic [31:0]  set_vals[$];
    logic         dropped;
    logic [1:0]   gap_mode;
    sorted_elem_t pending_elems[$];
    int           errors;

    function void set_gap_mode(logic [1:0] m);
      gap_mode = m;
    endfunction

    function void report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    // Gaps in descending order for a set of n elements
    function void build_gaps(int n, ref int gaps[$]);
      int p;
      int f0;
      int f1;
      int t;
      gaps = {};
      if (gap_mode == GAP_POW2M1) begin
        p = 1;
        while (p < n) begin
          gaps.push_front(p);
          p = 2 * p + 1;
        end
      end else if (gap_mode == GAP_FIB) begin
        f0 = 1;
        f1 = 2;
        if (n > 1) gaps.push_front(1);
        while (f1 < n) begin
          gaps.push_front(f1);
          t = f0 + f1;
          f0 = f1;
          f1 = t;
        end
      end else begin
        p = n / 2;
        while (p >= 1) begin
          gaps.push_back(p);
          p = p / 2;
        end
      end
    endfunction

    function void note_input(logic [31:0] v, logic lst);
      int gaps[$];
      int n;
      int j;
      logic [31:0] tmp;
      sorted_elem_t e;
      if (set_vals.size() < CAP) set_vals.push_back(v);
      else dropped = 1'b1;
      if (!lst) return;
      n = set_vals.size();
      build_gaps(n, gaps);
      foreach (gaps[s]) begin
        for (int i = gaps[s]; i < n; i++) begin
          tmp = set_vals[i];
          j = i;
          while (j >= gaps[s] && $signed(set_vals[j - gaps[s]]) > $signed(tmp)) begin
            set_vals[j] = set_vals[j - gaps[s]];
            j -= gaps[s];
          end
          set_vals[j] = tmp;
        end
      end
      for (int k = 0; k < n; k++) begin
        e.sorted_value = set_vals[k];
        e.final_res = (k == n - 1);
        e.overflow = dropped;
        pending_elems.push_back(e);
      end
      set_vals = {};
      dropped = 1'b0;
    endfunction

    function void check_result(sorted_elem_t got);
      sorted_elem_t exp_e;
      if (pending_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0h", got.sorted_value));
        return;
      end
      exp_e = pending_elems.pop_front();
      if (got.sorted_value !== exp_e.sorted_value)
        report_mismatch($sformatf("sorted_value %0h, want %0h",
                                  got.sorted_value, exp_e.sorted_value));
      if (got.final_res !== exp_e.final_res)
        report_mismatch($sformatf("final_res %0b, want %0b", got.final_res, exp_e.final_res));
      if (got.overflow !== exp_e.overflow)
        report_mismatch($sformatf("overflow %0b, want %0b", got.overflow, exp_e.overflow));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  bit          calm = 1'b0;
  bit          hold_long = 1'b0;
  sort_scoreboard sb;

  sse_in_if  in_ch ();
  sse_out_if out_ch ();

  shell_sort_engine u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Setup then access phase
  task automatic write_gap_mode(logic [1:0] m);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_GAP_MODE;
    pwdata <= {30'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_gap_mode(m);
  endtask

  // Offer one transaction, with random gap bursts unless calm
  task automatic send_elem(logic [31:0] v, logic lst);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(v, lst);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_elem(rand_value(), i == n - 1);
  endtask

  task automatic drain();
    int guard;
    idle_input();
    guard = 0;
    while (sb.pending_elems.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  // Result side: check each accepted result
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.sorted_value, out_ch.final_res, out_ch.overflow});
  end

  // Result side: random stall bursts, plus one long hold-off once results appear
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long && !held && out_ch.valid) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last = 1'b0;
    sb = new();
    sb.gap_mode = GAP_HALVING;
    sb.dropped = 1'b0;
    sb.errors = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single element, extremes, duplicates, reverse order
    send_elem(32'h8000_0000, 1'b1);
    send_elem(32'h7fff_ffff, 1'b0);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h0000_0000, 1'b0);
    send_elem(32'hffff_ffff, 1'b0);
    send_elem(32'h0000_0001, 1'b1);
    for (int i = 0; i < 8; i++) send_elem(32'd8 - i, i == 7);
    drain();
    write_gap_mode(GAP_POW2M1);
    for (int i = 0; i < 5; i++) send_elem(32'h5555_5555, i == 4);
    send_set(2);
    drain();
    write_gap_mode(GAP_FIB);
    send_set(13);
    drain();
    write_gap_mode(2'd3);
    send_set(6);
    drain();

    // Overflow: more than capacity, long receiver hold to fill and stall
    write_gap_mode(GAP_HALVING);
    hold_long = 1'b1;
    send_set(CAP + 3);
    send_set(4);
    drain();

    // Random small sets under every gap sequence
    for (int ph = 0; ph < 4; ph++) begin
      write_gap_mode(ph[1:0]);
      for (int s = 0; s < 2; s++) begin
        n = $urandom_range(1, 8);
        send_set(n);
      end
      drain();
    end

    // Quiet tail with no idling
    calm = 1'b1;
    write_gap_mode(GAP_FIB);
    for (int s = 0; s < 4; s++) send_set($urandom_range(1, 10));
    drain();

    if (sb.pending_elems.size() == 0 && sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
